[src/kped_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kped_pkg
// Shared types, sizes and codes of the key press event detector.
// ----------------------------------------------------------------------------
package kped_pkg;

  localparam int KEY_COUNT = 16;
  localparam int CODE_BITS = 5;
  localparam int IDX_BITS  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CNT_BITS  = $clog2(KEY_COUNT + 1);
  localparam int TICK_BITS = 16;
  localparam int KEY_BITS  = 4;
  localparam int KIND_BITS = 3;
  localparam int PH_BITS   = 3;
  localparam int CFG_BITS  = 2;

  localparam logic [PH_BITS-1:0] PH_WAIT     = 3'd0;
  localparam logic [PH_BITS-1:0] PH_DEBOUNCE = 3'd1;
  localparam logic [PH_BITS-1:0] PH_COUNT    = 3'd2;
  localparam logic [PH_BITS-1:0] PH_HELD     = 3'd3;
  localparam logic [PH_BITS-1:0] PH_RELEASED = 3'd4;

  localparam logic [KIND_BITS-1:0] EV_CLICK     = 3'd0;
  localparam logic [KIND_BITS-1:0] EV_LONG      = 3'd1;
  localparam logic [KIND_BITS-1:0] EV_CLICK_REL = 3'd2;
  localparam logic [KIND_BITS-1:0] EV_LONG_REL  = 3'd3;
  localparam logic [KIND_BITS-1:0] EV_CONT      = 3'd4;

  localparam logic [CFG_BITS-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_BITS-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_BITS-1:0] REG_REPEAT   = 2'd2;

  localparam logic [TICK_BITS-1:0] DEBOUNCE_RST = 16'd2;
  localparam logic [TICK_BITS-1:0] LONG_RST     = 16'd100;
  localparam logic [TICK_BITS-1:0] REPEAT_RST   = 16'd20;

  typedef struct packed {
    logic [PH_BITS-1:0]   phase;
    logic [TICK_BITS-1:0] debounce_count;
    logic [TICK_BITS-1:0] long_count;
    logic [TICK_BITS-1:0] repeat_count;
  } kped_entry_t;

  localparam kped_entry_t RESET_ENTRY = '{
    phase:          PH_WAIT,
    debounce_count: DEBOUNCE_RST,
    long_count:     LONG_RST,
    repeat_count:   REPEAT_RST
  };

  typedef struct packed {
    logic [TICK_BITS-1:0] debounce_ticks;
    logic [TICK_BITS-1:0] long_press_ticks;
    logic [TICK_BITS-1:0] repeat_ticks;
  } kped_cfg_t;

  typedef struct packed {
    kped_entry_t          entry;
    logic                 fire;
    logic [KIND_BITS-1:0] kind;
  } kped_step_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key_id;
    logic [KIND_BITS-1:0] kind;
  } kped_event_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key_id;
    logic [KIND_BITS-1:0] kind;
    logic                 last;
  } kped_result_t;

endpackage
`default_nettype wire

[src/kped_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kped_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module kped_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/kped_key_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kped_key_step
// Phase machine update of one key entry for one scan tick.
// ----------------------------------------------------------------------------
module kped_key_step (
  input  wire kped_pkg::kped_entry_t cur,
  input  wire logic                  pressed,
  input  wire kped_pkg::kped_cfg_t   cfg,
  output kped_pkg::kped_step_t       step
);
  import kped_pkg::*;

  logic [TICK_BITS-1:0] deb_dec;
  logic [TICK_BITS-1:0] long_dec;
  logic [TICK_BITS-1:0] rep_dec;

  assign deb_dec  = cur.debounce_count - 1'b1;
  assign long_dec = cur.long_count - 1'b1;
  assign rep_dec  = cur.repeat_count - 1'b1;

  always_comb begin
    step.entry = cur;
    step.fire  = 1'b0;
    step.kind  = EV_CLICK;
    unique case (cur.phase)
      PH_WAIT: begin
        if (pressed) begin
          step.entry.phase = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (pressed) begin
          if (deb_dec == '0) begin
            step.entry.debounce_count = cfg.debounce_ticks;
            step.entry.phase          = PH_COUNT;
            step.fire                 = 1'b1;
            step.kind                 = EV_CLICK;
          end else begin
            step.entry.debounce_count = deb_dec;
          end
        end else begin
          step.entry.debounce_count = cfg.debounce_ticks;
          step.entry.phase          = PH_WAIT;
        end
      end
      PH_COUNT: begin
        if (pressed) begin
          if (long_dec == '0) begin
            step.entry.long_count = cfg.long_press_ticks;
            step.entry.phase      = PH_HELD;
            step.fire             = 1'b1;
            step.kind             = EV_LONG;
          end else begin
            step.entry.long_count = long_dec;
          end
        end else begin
          step.entry.long_count = cfg.long_press_ticks;
          step.entry.phase      = PH_RELEASED;
          step.fire             = 1'b1;
          step.kind             = EV_CLICK_REL;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          step.entry.phase        = PH_RELEASED;
          step.entry.repeat_count = cfg.repeat_ticks;
          step.fire               = 1'b1;
          step.kind               = EV_LONG_REL;
        end else if (rep_dec == '0) begin
          step.entry.repeat_count = cfg.repeat_ticks;
          step.fire               = 1'b1;
          step.kind               = EV_CONT;
        end else begin
          step.entry.repeat_count = rep_dec;
        end
      end
      PH_RELEASED: begin
        if (!pressed) begin
          step.entry.phase = PH_WAIT;
        end
      end
      default: begin
        step.entry.phase = PH_WAIT;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/kped_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kped_outq
// Two-slot result queue; loads the events of one tick, drains one per
// transaction and marks the final one.
// ----------------------------------------------------------------------------
module kped_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic                  load_two,
  input  wire kped_pkg::kped_event_t ev0,
  input  wire kped_pkg::kped_event_t ev1,
  output logic                       empty,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output kped_pkg::kped_result_t     head
);
  import kped_pkg::*;

  kped_result_t slot0;
  kped_result_t slot1;
  logic [1:0]   count;

  assign empty     = (count == 2'd0);
  assign out_valid = !empty;
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      slot0 <= '{key_id: ev0.key_id, kind: ev0.kind, last: !load_two};
      slot1 <= '{key_id: ev1.key_id, kind: ev1.kind, last: 1'b1};
      count <= load_two ? 2'd2 : 2'd1;
    end else if (out_valid && out_ready) begin
      slot0 <= slot1;
      count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

[src/key_press_event_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ticks: a new tick is taken only once the previous scan is done and
// its events are loaded into the result queue; the key state memory is
// walked one key per cycle through its single read port.
// Reset: registers take 2, 100 and 20; per-key valid bits clear at once, so
// every key reads as waiting with reset counts until first written.
// ----------------------------------------------------------------------------
// key_press_event_detector
// Debounce, long press and auto-repeat for keys on an encoded scan bus.
// ----------------------------------------------------------------------------
module key_press_event_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [kped_pkg::CODE_BITS-1:0]    line_code,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [kped_pkg::KEY_BITS-1:0]     key_id,
  output logic      [kped_pkg::KIND_BITS-1:0]    event_kind,
  output logic                                   last_event,
  input  wire logic                              cfg_write,
  input  wire logic [kped_pkg::CFG_BITS-1:0]     cfg_index,
  input  wire logic [kped_pkg::TICK_BITS-1:0]    cfg_data
);
  import kped_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state;
  kped_cfg_t            cfg;
  logic [CODE_BITS-1:0] code;
  logic [CNT_BITS-1:0]  rd_cnt;
  logic                 p_valid;
  logic [IDX_BITS-1:0]  p_idx;
  logic                 rd_ok;
  logic [KEY_COUNT-1:0] ent_valid;
  logic [1:0]           ev_cnt;
  kped_event_t          ev0;
  kped_event_t          ev1;

  logic                 rd_en;
  logic [IDX_BITS-1:0]  rd_idx;
  kped_entry_t          ram_rdata;
  kped_entry_t          cur;
  logic                 pressed;
  kped_step_t           step;
  kped_event_t          new_ev;
  logic                 outq_empty;
  logic                 outq_load;
  kped_result_t         head;

  assign in_ready = (state == ST_IDLE);
  assign rd_idx   = rd_cnt[IDX_BITS-1:0];
  assign rd_en    = (state == ST_SCAN) && (int'(rd_cnt) < KEY_COUNT);
  assign cur      = rd_ok ? ram_rdata : RESET_ENTRY;
  assign pressed  = (int'(code) >= 1) && (int'(code) <= KEY_COUNT)
                    && (int'(code) - 1 == int'(p_idx));
  assign new_ev   = '{key_id: KEY_BITS'(p_idx), kind: step.kind};
  assign outq_load = (state == ST_DONE) && (ev_cnt != 2'd0) && outq_empty;

  kped_ram #(
    .WIDTH ($bits(kped_entry_t)),
    .DEPTH (KEY_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (p_valid),
    .waddr (p_idx),
    .wdata (step.entry),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  kped_key_step u_step (
    .cur     (cur),
    .pressed (pressed),
    .cfg     (cfg),
    .step    (step)
  );

  kped_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (outq_load),
    .load_two  (ev_cnt == 2'd2),
    .ev0       (ev0),
    .ev1       (ev1),
    .empty     (outq_empty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign key_id     = head.key_id;
  assign event_kind = head.kind;
  assign last_event = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_cnt    <= '0;
      p_valid   <= 1'b0;
      ent_valid <= '0;
      ev_cnt    <= 2'd0;
      cfg       <= '{debounce_ticks: DEBOUNCE_RST, long_press_ticks: LONG_RST,
                     repeat_ticks: REPEAT_RST};
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DEBOUNCE: cfg.debounce_ticks   <= cfg_data;
          REG_LONG:     cfg.long_press_ticks <= cfg_data;
          REG_REPEAT:   cfg.repeat_ticks     <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          p_valid <= 1'b0;
          if (in_valid) begin
            code   <= line_code;
            rd_cnt <= '0;
            ev_cnt <= 2'd0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          p_valid <= rd_en;
          if (rd_en) begin
            rd_cnt <= rd_cnt + 1'b1;
            p_idx  <= rd_idx;
            rd_ok  <= ent_valid[rd_idx];
          end
          if (p_valid) begin
            ent_valid[p_idx] <= 1'b1;
            if (step.fire && ev_cnt != 2'd2) begin
              if (ev_cnt == 2'd0) begin
                ev0 <= new_ev;
              end else begin
                ev1 <= new_ev;
              end
              ev_cnt <= ev_cnt + 2'd1;
            end
            if (int'(p_idx) == KEY_COUNT - 1) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          p_valid <= 1'b0;
          if (ev_cnt == 2'd0 || outq_empty) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          p_valid <= 1'b0;
          state   <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[src/kped_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kped_checker
// Port-level checks of the key press event detector, bound to the top level.
// ----------------------------------------------------------------------------
module kped_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [kped_pkg::KEY_BITS-1:0]     key_id,
  input wire logic [kped_pkg::KIND_BITS-1:0]    event_kind,
  input wire logic                              last_event
);
  import kped_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second tick taken while a scan runs");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind <= EV_CONT))
    else $error("event kind out of range");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_event) |=> out_valid)
    else $error("tick ended without a final event");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(key_id)
      && $stable(event_kind) && $stable(last_event)))
    else $error("stalled result changed");

endmodule

bind key_press_event_detector kped_checker u_kped_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .key_id     (key_id),
  .event_kind (event_kind),
  .last_event (last_event)
);
`default_nettype wire
